[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define IAE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define IAE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define IAE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IAE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/iae_pkg.sv]
// ----------------------------------------------------------------------------
// iae_pkg
// Types and constants shared by the integer ALU with GCD/LCM.
// ----------------------------------------------------------------------------
`default_nettype none
package iae_pkg;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DATA_W + 1);

    // operation codes
    localparam logic [2:0] KIND_ADD = 3'd0;
    localparam logic [2:0] KIND_SUB = 3'd1;
    localparam logic [2:0] KIND_MUL = 3'd2;
    localparam logic [2:0] KIND_DIV = 3'd3;
    localparam logic [2:0] KIND_LCM = 3'd4;
    localparam logic [2:0] KIND_GCD = 3'd5;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_DIV_ZERO = 2'd1,
        ERR_NOT_POS  = 2'd2,
        ERR_OVERFLOW = 2'd3
    } iae_err_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_GCD,
        S_LDIV,
        S_MUL,
        S_MULR,
        S_OUT
    } iae_state_t;

    typedef struct packed {
        logic [2:0]               kind;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } iae_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        iae_err_t                 error_code;
    } iae_rsp_t;
endpackage
`default_nettype wire

[design/integer_alu_gcd_lcm.sv]
// ----------------------------------------------------------------------------
// integer_alu_gcd_lcm
// Signed 32-bit ALU: add, subtract, multiply, divide, LCM and GCD.
// ----------------------------------------------------------------------------
//   channel  | signals                 | handshake
//   request  | start, req (iae_req_t)  | taken when start && !busy
//   result   | done, result (iae_rsp_t)| one cycle, receiver cannot stall
//
// Per request: add, subtract, unused kinds and rejected operands go straight
// from decode to the result; multiply passes S_MUL and S_MULR; divide runs the
// 32 divider steps plus handoff; GCD runs binary GCD, one shift or subtract per
// cycle; LCM adds a divide and the S_MUL and S_MULR states after the GCD.
// busy is high from the cycle after the take until the result cycle ends.
// Reset clears the sequencer; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"
module integer_alu_gcd_lcm (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire iae_pkg::iae_req_t req,
    output logic                   busy,
    output logic                   done,
    output iae_pkg::iae_rsp_t      result
);
    localparam int W = iae_pkg::DATA_W;

    iae_pkg::iae_state_t state_reg, state_next;
    iae_pkg::iae_req_t   req_reg, req_next;
    iae_pkg::iae_rsp_t   res_reg, res_next;
    logic [W-1:0]        mul_x_reg, mul_x_next;
    logic [W-1:0]        mul_y_reg, mul_y_next;
    logic [2*W-1:0]      prod_reg;

    logic                div_start, div_done;
    logic [W-1:0]        div_dividend, div_divisor, div_q;
    logic                gcd_start, gcd_done;
    logic [W-1:0]        gcd_val;
    logic [W-1:0]        a_u, b_u, a_mag, b_mag;
    logic                a_bad, b_bad;

    iae_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    iae_gcd u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .x_in  (a_u),
        .y_in  (b_u),
        .done  (gcd_done),
        .gcd   (gcd_val)
    );

    // operand views
    always_comb
    begin
        a_u   = req_reg.operand_a;
        b_u   = req_reg.operand_b;
        a_mag = a_u[W-1] ? (~a_u + 1'b1) : a_u;
        b_mag = b_u[W-1] ? (~b_u + 1'b1) : b_u;
        a_bad = (a_u == '0) || a_u[W-1];
        b_bad = (b_u == '0) || b_u[W-1];
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        res_next     = res_reg;
        mul_x_next   = mul_x_reg;
        mul_y_next   = mul_y_reg;
        div_start    = 1'b0;
        div_dividend = a_mag;
        div_divisor  = b_mag;
        gcd_start    = 1'b0;
        unique case (state_reg)
            iae_pkg::S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    state_next = iae_pkg::S_DECODE;
                end
            end
            iae_pkg::S_DECODE:
            begin
                res_next.value      = '0;
                res_next.error_code = iae_pkg::ERR_OK;
                state_next          = iae_pkg::S_OUT;
                unique case (req_reg.kind)
                    iae_pkg::KIND_ADD: res_next.value = a_u + b_u;
                    iae_pkg::KIND_SUB: res_next.value = a_u - b_u;
                    iae_pkg::KIND_MUL:
                    begin
                        mul_x_next = a_u;
                        mul_y_next = b_u;
                        state_next = iae_pkg::S_MUL;
                    end
                    iae_pkg::KIND_DIV:
                    begin
                        priority if (b_u == '0)
                            res_next.error_code = iae_pkg::ERR_DIV_ZERO;
                        else if (a_u == {1'b1, {(W-1){1'b0}}} && b_u == '1)
                            res_next.error_code = iae_pkg::ERR_OVERFLOW;
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = iae_pkg::S_DIV;
                        end
                    end
                    iae_pkg::KIND_LCM, iae_pkg::KIND_GCD:
                    begin
                        if (a_bad || b_bad)
                            res_next.error_code = iae_pkg::ERR_NOT_POS;
                        else
                        begin
                            gcd_start  = 1'b1;
                            state_next = iae_pkg::S_GCD;
                        end
                    end
                    default: ;
                endcase
            end
            iae_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    res_next.value = (a_u[W-1] ^ b_u[W-1]) ? (~div_q + 1'b1) : div_q;
                    state_next     = iae_pkg::S_OUT;
                end
            end
            iae_pkg::S_GCD:
            begin
                if (gcd_done)
                begin
                    if (req_reg.kind == iae_pkg::KIND_GCD)
                    begin
                        res_next.value = gcd_val;
                        state_next     = iae_pkg::S_OUT;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = a_u;
                        div_divisor  = gcd_val;
                        state_next   = iae_pkg::S_LDIV;
                    end
                end
            end
            iae_pkg::S_LDIV:
            begin
                if (div_done)
                begin
                    mul_x_next = div_q;
                    mul_y_next = b_u;
                    state_next = iae_pkg::S_MUL;
                end
            end
            iae_pkg::S_MUL:
            begin
                state_next = iae_pkg::S_MULR;
            end
            iae_pkg::S_MULR:
            begin
                // LCM must stay at or below the largest positive value
                if (req_reg.kind == iae_pkg::KIND_LCM && prod_reg[2*W-1:W-1] != '0)
                    res_next.error_code = iae_pkg::ERR_OVERFLOW;
                else
                    res_next.value = prod_reg[W-1:0];
                state_next = iae_pkg::S_OUT;
            end
            iae_pkg::S_OUT:
            begin
                state_next = iae_pkg::S_IDLE;
            end
            default: state_next = iae_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= iae_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // payload registers and the shared multiplier
    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        res_reg   <= res_next;
        mul_x_reg <= mul_x_next;
        mul_y_reg <= mul_y_next;
        prod_reg  <= {{W{1'b0}}, mul_x_reg} * {{W{1'b0}}, mul_y_reg};
    end

    assign busy   = (state_reg != iae_pkg::S_IDLE);
    assign done   = (state_reg == iae_pkg::S_OUT);
    assign result = res_reg;

    `IAE_ASSERT_IMP(a_err_zero, clk, rst_n, done && result.error_code != iae_pkg::ERR_OK, result.value == '0)
    `IAE_ASSERT_NXT(a_done_pulse, clk, rst_n, done, !done)
    `IAE_ASSERT_NXT(a_take_busy, clk, rst_n, start && !busy, busy && !done)
endmodule
`default_nettype wire

[design/iae_divider.sv]
// ----------------------------------------------------------------------------
// iae_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module iae_divider (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [iae_pkg::DATA_W-1:0] dividend,
    input  wire logic [iae_pkg::DATA_W-1:0] divisor,
    output logic                           done,
    output logic [iae_pkg::DATA_W-1:0]     quotient
);
    localparam int W = iae_pkg::DATA_W;
    localparam logic [iae_pkg::CNT_W-1:0] LAST = iae_pkg::CNT_W'(W - 1);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [iae_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [W-1:0]               rem_reg, rem_next;
    logic [W-1:0]               quo_reg, quo_next;
    logic [W-1:0]               dsr_reg, dsr_next;
    logic [W:0]                 shifted;
    logic [W:0]                 diff;

    // one trial subtraction per cycle
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

[design/iae_gcd.sv]
// ----------------------------------------------------------------------------
// iae_gcd
// Binary GCD: one shift or one subtract per cycle on positive operands.
// ----------------------------------------------------------------------------
`default_nettype none
module iae_gcd (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [iae_pkg::DATA_W-1:0] x_in,
    input  wire logic [iae_pkg::DATA_W-1:0] y_in,
    output logic                           done,
    output logic [iae_pkg::DATA_W-1:0]     gcd
);
    localparam int W = iae_pkg::DATA_W;

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [iae_pkg::CNT_W-1:0] k_reg, k_next;
    logic [W-1:0]              x_reg, x_next;
    logic [W-1:0]              y_reg, y_next;
    logic [W-1:0]              g_reg, g_next;

    // reduce until one operand is zero, then restore the common twos
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        k_next    = k_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        g_next    = g_reg;
        if (start)
        begin
            busy_next = 1'b1;
            k_next    = '0;
            x_next    = x_in;
            y_next    = y_in;
        end
        else if (busy_reg)
        begin
            priority if (x_reg == '0 || y_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                g_next    = (x_reg | y_reg) << k_reg;
            end
            else if (!x_reg[0] && !y_reg[0])
            begin
                x_next = x_reg >> 1;
                y_next = y_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!x_reg[0])
            begin
                x_next = x_reg >> 1;
            end
            else if (!y_reg[0])
            begin
                y_next = y_reg >> 1;
            end
            else if (x_reg >= y_reg)
            begin
                x_next = x_reg - y_reg;
            end
            else
            begin
                y_next = y_reg - x_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        x_reg <= x_next;
        y_reg <= y_next;
        g_reg <= g_next;
    end

    assign done = done_reg;
    assign gcd  = g_reg;
endmodule
`default_nettype wire
